// ----- hw/rtl/deque_with_reverse_and_search_unit_defines.svh -----
// Assertion macros for the deque unit.
// Included by the top level; depends on nothing else.
`ifndef DEQUE_WITH_REVERSE_AND_SEARCH_UNIT_DEFINES_SVH
`define DEQUE_WITH_REVERSE_AND_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DQRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DQRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/dqrs_pkg.sv -----
// Shared constants, codes, types and ring index helpers for the deque unit.
// Used by dqrs_core, deque_with_reverse_and_search_unit and the testbench; depends on nothing.
package dqrs_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int PTR_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 3;

   // Operation codes carried by the mode field.
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_SEARCH     = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = MODE_W'(4);
   localparam logic [MODE_W-1:0] MODE_REVERSE    = MODE_W'(5);

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_EMPTY     = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FULL      = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_FOUND     = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = STATUS_W'(4);

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_POP,
      CORE_SEARCH,
      CORE_HOLD
   } core_state_type;

   // One finished result, passed from the core to the output register.
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_WIDTH-1:0] removed;
      logic [CNT_W-1:0]       fill;
   } result_type;

   // Ring index one step towards the back.
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // Ring index one step towards the front.
   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == '0) begin
         r = PTR_W'(CAPACITY - 1);
      end else begin
         r = p - 1'b1;
      end
      return r;
   endfunction

   // Ring index n places behind p, for n no greater than the capacity.
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
      int s;
      s = int'(p) + int'(n);
      if (s >= CAPACITY) begin
         s = s - CAPACITY;
      end
      return PTR_W'(s);
   endfunction

endpackage

// ----- hw/rtl/dqrs_core.sv -----
// Deque sequencer with its entry memory, pointers, count and direction flag.
// Depends on dqrs_pkg; results leave through a result_type struct.
module dqrs_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dqrs_pkg::MODE_W-1:0]         req_mode,
   input  logic [dqrs_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                res_valid,
   input  logic                                res_take,
   output dqrs_pkg::result_type                res
);

   // Entry memory: one write port, one registered read port.
   logic [dqrs_pkg::VALUE_WIDTH-1:0] entry_mem [dqrs_pkg::CAPACITY];
   logic [dqrs_pkg::VALUE_WIDTH-1:0] rd_data_ff;

   logic                             mem_we;
   logic [dqrs_pkg::PTR_W-1:0]       mem_waddr;
   logic [dqrs_pkg::VALUE_WIDTH-1:0] mem_wdata;
   logic                             mem_re;
   logic [dqrs_pkg::PTR_W-1:0]       mem_raddr;

   dqrs_pkg::core_state_type         state_ff, state_in;
   logic [dqrs_pkg::PTR_W-1:0]       front_ff, front_in;
   logic [dqrs_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                             rev_ff, rev_in;
   logic [dqrs_pkg::VALUE_WIDTH-1:0] op_value_ff, op_value_in;
   logic [dqrs_pkg::PTR_W-1:0]       walk_ptr_ff, walk_ptr_in;
   logic [dqrs_pkg::CNT_W-1:0]       walk_cnt_ff, walk_cnt_in;
   logic [dqrs_pkg::STATUS_W-1:0]    pend_status_ff, pend_status_in;
   logic [dqrs_pkg::VALUE_WIDTH-1:0] pend_removed_ff, pend_removed_in;

   // Memory array; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[mem_raddr];
      end
   end

   // Control state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqrs_pkg::CORE_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   // Operand, search walk and pending result registers.
   always_ff @(posedge clock) begin
      op_value_ff     <= op_value_in;
      walk_ptr_ff     <= walk_ptr_in;
      walk_cnt_ff     <= walk_cnt_in;
      pend_status_ff  <= pend_status_in;
      pend_removed_ff <= pend_removed_in;
   end

   // Sequencer: requests are stalled whenever the core is not idle, so no two
   // memory accesses of different operations ever overlap.
   always_comb begin
      logic at_head;
      at_head         = 1'b0;
      state_in        = state_ff;
      front_in        = front_ff;
      count_in        = count_ff;
      rev_in          = rev_ff;
      op_value_in     = op_value_ff;
      walk_ptr_in     = walk_ptr_ff;
      walk_cnt_in     = walk_cnt_ff;
      pend_status_in  = pend_status_ff;
      pend_removed_in = pend_removed_ff;
      mem_we          = 1'b0;
      mem_waddr       = front_ff;
      mem_wdata       = req_value;
      mem_re          = 1'b0;
      mem_raddr       = front_ff;
      req_stall       = (state_ff != dqrs_pkg::CORE_IDLE);
      res_valid       = (state_ff == dqrs_pkg::CORE_HOLD);

      case (state_ff)
         dqrs_pkg::CORE_IDLE: begin
            if (req_valid) begin
               op_value_in     = req_value;
               pend_status_in  = dqrs_pkg::ST_OK;
               pend_removed_in = '0;
               state_in        = dqrs_pkg::CORE_HOLD;
               case (req_mode)
                  dqrs_pkg::MODE_PUSH_FRONT, dqrs_pkg::MODE_PUSH_BACK: begin
                     // The logical front is the physical head unless reversed.
                     at_head = (req_mode == dqrs_pkg::MODE_PUSH_FRONT) ^ rev_ff;
                     if (count_ff == dqrs_pkg::CNT_W'(dqrs_pkg::CAPACITY)) begin
                        pend_status_in = dqrs_pkg::ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        if (at_head) begin
                           front_in  = dqrs_pkg::ring_prev(front_ff);
                           mem_waddr = dqrs_pkg::ring_prev(front_ff);
                        end else begin
                           mem_waddr = dqrs_pkg::ring_add(front_ff, count_ff);
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dqrs_pkg::MODE_POP_FRONT, dqrs_pkg::MODE_POP_BACK: begin
                     at_head = (req_mode == dqrs_pkg::MODE_POP_FRONT) ^ rev_ff;
                     if (count_ff == '0) begin
                        pend_status_in = dqrs_pkg::ST_EMPTY;
                     end else begin
                        mem_re = 1'b1;
                        if (at_head) begin
                           mem_raddr = front_ff;
                           front_in  = dqrs_pkg::ring_next(front_ff);
                        end else begin
                           mem_raddr = dqrs_pkg::ring_add(front_ff, count_ff - 1'b1);
                        end
                        count_in = count_ff - 1'b1;
                        state_in = dqrs_pkg::CORE_POP;
                     end
                  end
                  dqrs_pkg::MODE_SEARCH: begin
                     if (count_ff == '0) begin
                        pend_status_in = dqrs_pkg::ST_NOT_FOUND;
                     end else begin
                        mem_re      = 1'b1;
                        mem_raddr   = front_ff;
                        walk_ptr_in = dqrs_pkg::ring_next(front_ff);
                        walk_cnt_in = dqrs_pkg::CNT_W'(1);
                        state_in    = dqrs_pkg::CORE_SEARCH;
                     end
                  end
                  dqrs_pkg::MODE_REVERSE: begin
                     rev_in = !rev_ff;
                  end
                  default: begin
                     // Unused codes leave the state alone and report ok.
                  end
               endcase
            end
         end
         dqrs_pkg::CORE_POP: begin
            pend_removed_in = rd_data_ff;
            state_in        = dqrs_pkg::CORE_HOLD;
         end
         dqrs_pkg::CORE_SEARCH: begin
            // Compare the entry read last cycle while the next one is read.
            if (rd_data_ff == op_value_ff) begin
               pend_status_in = dqrs_pkg::ST_FOUND;
               state_in       = dqrs_pkg::CORE_HOLD;
            end else if (walk_cnt_ff == count_ff) begin
               pend_status_in = dqrs_pkg::ST_NOT_FOUND;
               state_in       = dqrs_pkg::CORE_HOLD;
            end else begin
               mem_re      = 1'b1;
               mem_raddr   = walk_ptr_ff;
               walk_ptr_in = dqrs_pkg::ring_next(walk_ptr_ff);
               walk_cnt_in = walk_cnt_ff + 1'b1;
            end
         end
         dqrs_pkg::CORE_HOLD: begin
            if (res_take) begin
               state_in = dqrs_pkg::CORE_IDLE;
            end
         end
         default: begin
            state_in = dqrs_pkg::CORE_IDLE;
         end
      endcase
   end

   assign res.status  = pend_status_ff;
   assign res.removed = pend_removed_ff;
   assign res.fill    = count_ff;

endmodule

// ----- hw/rtl/deque_with_reverse_and_search_unit.sv -----
// Channel   Ports                                   Direction
// req       req_valid req_stall req_mode req_value   in (stall out)
// rsp       rsp_valid rsp_stall rsp_status           out (stall in)
//           rsp_removed_value rsp_fill_count
//
// A push, a reverse or an unused code passes its result from the core's pending result registers to the
// output register, and the core takes the next request once the result has moved into that register.
// A pop first waits for the entry memory read, then takes the same path.
// A search compares one entry per cycle through the single read port and stops at a match
// or at the fill count, then takes the same path.
// A stalled result holds the output register; the core waits and stalls the next request.
// Reset is synchronous and empties the deque by clearing its count and pointers; no clearing pass.
//
// Top level of the deque unit: output register, core and checks.
// Depends on dqrs_pkg, dqrs_core and deque_with_reverse_and_search_unit_defines.svh.
`include "deque_with_reverse_and_search_unit_defines.svh"

module deque_with_reverse_and_search_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [dqrs_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [dqrs_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [dqrs_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [dqrs_pkg::VALUE_WIDTH-1:0] rsp_removed_value,
   output logic [dqrs_pkg::CNT_W-1:0]              rsp_fill_count
);

   logic                 core_valid;
   logic                 out_free;
   dqrs_pkg::result_type core_res;
   logic                 rsp_valid_ff, rsp_valid_in;
   dqrs_pkg::result_type rsp_res_ff, rsp_res_in;

   dqrs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_value (req_value),
      .res_valid (core_valid),
      .res_take  (out_free),
      .res       (core_res)
   );

   // The output register is free when empty or when its transfer completes.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_res_in   = rsp_res_ff;
      if (core_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_res_ff.status;
   assign rsp_removed_value = rsp_res_ff.removed;
   assign rsp_fill_count    = rsp_res_ff.fill;

   // A dropped push can only be reported with the deque full.
   `DQRS_ASSERT_IMP(a_full_at_capacity, clock, reset,
      rsp_valid_ff && (rsp_res_ff.status == dqrs_pkg::ST_FULL),
      rsp_res_ff.fill == dqrs_pkg::CNT_W'(dqrs_pkg::CAPACITY),
      "full status with fill count below capacity")

   // An empty pop reports no entries and no value.
   `DQRS_ASSERT_IMP(a_empty_is_empty, clock, reset,
      rsp_valid_ff && (rsp_res_ff.status == dqrs_pkg::ST_EMPTY),
      (rsp_res_ff.fill == '0) && (rsp_res_ff.removed == '0),
      "empty status with entries or a removed value")

   // Only a successful pop carries a removed value.
   `DQRS_ASSERT_IMP(a_removed_only_ok, clock, reset,
      rsp_valid_ff && (rsp_res_ff.status != dqrs_pkg::ST_OK),
      rsp_res_ff.removed == '0,
      "removed value on a result that is not ok")

   // A result handed over by the core shows at the port in the next cycle.
   `DQRS_ASSERT_NEXT(a_handover_shows, clock, reset,
      core_valid && out_free,
      rsp_valid_ff,
      "core result lost at the output register")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for deque_with_reverse_and_search_unit.
// A tracker class mirrors the deque and checks every result; plain tasks drive the block.
// Depends on dqrs_pkg and the deque_with_reverse_and_search_unit RTL.
module testbench;

   // Mode codes with no operation behind them.
   localparam logic [dqrs_pkg::MODE_W-1:0] MODE_SPARE_A = dqrs_pkg::MODE_W'(6);
   localparam logic [dqrs_pkg::MODE_W-1:0] MODE_SPARE_B = dqrs_pkg::MODE_W'(7);

   localparam int RANDOM_OPS   = 600;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RESET_CYCLES = 11;

   typedef logic signed [dqrs_pkg::VALUE_WIDTH-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(dqrs_pkg::VALUE_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(dqrs_pkg::VALUE_WIDTH-1){1'b0}}};

   typedef struct {
      logic [dqrs_pkg::STATUS_W-1:0] status;
      word_type                      removed;
      logic [dqrs_pkg::CNT_W-1:0]    fill;
   } deque_result_type;

   // Mirror of the deque contents and the queue of results still owed by the block.
   class deque_tracker;
      word_type         shadow_store [dqrs_pkg::CAPACITY];
      int unsigned      shadow_head;
      int unsigned      shadow_count;
      bit               shadow_flipped;
      deque_result_type pending_results [$];
      int unsigned      mismatches;

      // Place a value at the physical head or tail of the ring.
      function logic [dqrs_pkg::STATUS_W-1:0] insert_entry(bit at_head, word_type value);
         if (shadow_count >= dqrs_pkg::CAPACITY) begin
            return dqrs_pkg::ST_FULL;
         end
         if (at_head) begin
            shadow_head = (shadow_head + dqrs_pkg::CAPACITY - 1) % dqrs_pkg::CAPACITY;
            shadow_store[shadow_head] = value;
         end else begin
            shadow_store[(shadow_head + shadow_count) % dqrs_pkg::CAPACITY] = value;
         end
         shadow_count++;
         return dqrs_pkg::ST_OK;
      endfunction

      // Take a value from the physical head or tail of the ring.
      function logic [dqrs_pkg::STATUS_W-1:0] remove_entry(bit at_head,
                                                           output word_type value);
         value = '0;
         if (shadow_count == 0) begin
            return dqrs_pkg::ST_EMPTY;
         end
         if (at_head) begin
            value = shadow_store[shadow_head];
            shadow_head = (shadow_head + 1) % dqrs_pkg::CAPACITY;
         end else begin
            value = shadow_store[(shadow_head + shadow_count - 1) % dqrs_pkg::CAPACITY];
         end
         shadow_count--;
         return dqrs_pkg::ST_OK;
      endfunction

      // Work out the result of one accepted operation and queue it.
      function void apply_operation(logic [dqrs_pkg::MODE_W-1:0] mode, word_type value);
         deque_result_type r;
         word_type         taken;
         r.status = dqrs_pkg::ST_OK;
         taken    = '0;
         case (mode)
            dqrs_pkg::MODE_PUSH_FRONT: r.status = insert_entry(!shadow_flipped, value);
            dqrs_pkg::MODE_PUSH_BACK:  r.status = insert_entry(shadow_flipped, value);
            dqrs_pkg::MODE_SEARCH: begin
               r.status = dqrs_pkg::ST_NOT_FOUND;
               for (int i = 0; i < shadow_count; i++) begin
                  if (shadow_store[(shadow_head + i) % dqrs_pkg::CAPACITY] == value) begin
                     r.status = dqrs_pkg::ST_FOUND;
                  end
               end
            end
            dqrs_pkg::MODE_POP_FRONT:  r.status = remove_entry(!shadow_flipped, taken);
            dqrs_pkg::MODE_POP_BACK:   r.status = remove_entry(shadow_flipped, taken);
            dqrs_pkg::MODE_REVERSE:    shadow_flipped = !shadow_flipped;
            default: begin
            end
         endcase
         r.removed = taken;
         r.fill    = dqrs_pkg::CNT_W'(shadow_count);
         pending_results.push_back(r);
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_result(logic [dqrs_pkg::STATUS_W-1:0] status, word_type removed,
                                 logic [dqrs_pkg::CNT_W-1:0] fill);
         deque_result_type e;
         if (pending_results.size() == 0) begin
            $error("Result transfer with no operation outstanding: status %0d", status);
            mismatches++;
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            mismatches++;
         end
         if (removed !== e.removed) begin
            $error("removed_value: expected %0d, actual %0d", e.removed, removed);
            mismatches++;
         end
         if (fill !== e.fill) begin
            $error("fill_count: expected %0d, actual %0d", e.fill, fill);
            mismatches++;
         end
      endfunction

      // A value currently held, so that searches and duplicates hit real entries.
      function word_type held_value();
         if (shadow_count == 0) begin
            return word_type'($urandom);
         end
         return shadow_store[(shadow_head + $urandom_range(0, shadow_count - 1))
                             % dqrs_pkg::CAPACITY];
      endfunction
   endclass

   logic                                    clock     = 1'b0;
   logic                                    reset     = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic [dqrs_pkg::MODE_W-1:0]             req_mode  = dqrs_pkg::MODE_PUSH_FRONT;
   logic signed [dqrs_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic [dqrs_pkg::STATUS_W-1:0]           rsp_status;
   logic signed [dqrs_pkg::VALUE_WIDTH-1:0] rsp_removed_value;
   logic [dqrs_pkg::CNT_W-1:0]              rsp_fill_count;

   deque_tracker tracker;
   int unsigned  cycle_count = 0;
   int unsigned  quiet_sends = 0;

   deque_with_reverse_and_search_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_fill_count    (rsp_fill_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle length in cycles: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   // A value with a bias towards the extremes and towards entries already held.
   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return WORD_MAX;
      end else if (r < 6) begin
         return WORD_MIN;
      end else if (r < 8) begin
         return '0;
      end else if (r < 10) begin
         return '1;
      end else if (r < 30) begin
         return tracker.held_value();
      end
      return word_type'($urandom);
   endfunction

   // Offer one operation, after a random gap except during a run of quiet sends, and hold it until the transfer.
   task automatic send_op(logic [dqrs_pkg::MODE_W-1:0] mode, word_type value);
      int gap;
      gap = 0;
      if (quiet_sends > 0) begin
         quiet_sends--;
      end else begin
         gap = idle_length();
         if ($urandom_range(0, 49) == 0) begin
            quiet_sends = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.apply_operation(mode, value);
   endtask

   // Edge cases first: empty store, spare codes, extreme values, a full store.
   task automatic run_directed_ops();
      send_op(dqrs_pkg::MODE_SEARCH, '0);
      send_op(dqrs_pkg::MODE_POP_FRONT, '0);
      send_op(dqrs_pkg::MODE_POP_BACK, '0);
      send_op(dqrs_pkg::MODE_REVERSE, '0);
      send_op(MODE_SPARE_A, WORD_MAX);
      send_op(MODE_SPARE_B, WORD_MIN);
      send_op(dqrs_pkg::MODE_REVERSE, '0);
      send_op(dqrs_pkg::MODE_PUSH_FRONT, WORD_MAX);
      send_op(dqrs_pkg::MODE_PUSH_BACK, WORD_MIN);
      send_op(dqrs_pkg::MODE_PUSH_FRONT, '0);
      send_op(dqrs_pkg::MODE_PUSH_BACK, '1);
      send_op(dqrs_pkg::MODE_SEARCH, WORD_MIN);
      for (int i = 0; i < dqrs_pkg::CAPACITY - 4; i++) begin
         send_op((i % 2 == 0) ? dqrs_pkg::MODE_PUSH_FRONT : dqrs_pkg::MODE_PUSH_BACK,
                 word_type'($urandom));
      end
      send_op(dqrs_pkg::MODE_PUSH_FRONT, WORD_MAX);
      send_op(dqrs_pkg::MODE_PUSH_BACK, WORD_MIN);
      send_op(dqrs_pkg::MODE_REVERSE, '0);
      send_op(dqrs_pkg::MODE_POP_FRONT, '0);
   endtask

   // Random operations in phases that lean towards filling or towards draining.
   task automatic run_random_ops();
      int                          phase_left;
      int                          push_bias;
      int                          pick;
      logic [dqrs_pkg::MODE_W-1:0] mode;
      word_type                    value;
      phase_left = 0;
      push_bias  = 50;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (phase_left == 0) begin
            push_bias  = $urandom_range(15, 85);
            phase_left = $urandom_range(20, 70);
         end
         phase_left--;
         pick  = $urandom_range(0, 99);
         value = pick_value();
         if (pick < 3) begin
            mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
         end else if (pick < 9) begin
            mode = dqrs_pkg::MODE_REVERSE;
         end else if (pick < 22) begin
            mode = dqrs_pkg::MODE_SEARCH;
            if ($urandom_range(0, 99) < 60) begin
               value = tracker.held_value();
            end
         end else if ($urandom_range(0, 99) < push_bias) begin
            mode = $urandom_range(0, 1) ? dqrs_pkg::MODE_PUSH_FRONT : dqrs_pkg::MODE_PUSH_BACK;
         end else begin
            mode = $urandom_range(0, 1) ? dqrs_pkg::MODE_POP_FRONT : dqrs_pkg::MODE_POP_BACK;
         end
         send_op(mode, value);
      end
   endtask

   // Stimulus, then wait for every owed result and report.
   initial begin
      tracker = new;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed_ops();
      run_random_ops();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Result side back-pressure: random stalls with occasional long free runs.
   initial begin
      int hold;
      int run;
      while (reset) @(posedge clock);
      forever begin
         hold = idle_length();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         run = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
         repeat (run) @(posedge clock);
      end
   end

   // Check each result transfer as it happens.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         tracker.check_result(rsp_status, rsp_removed_value, rsp_fill_count);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dqrs_pkg.sv
hw/rtl/dqrs_core.sv
hw/rtl/deque_with_reverse_and_search_unit.sv
dv/testbench.sv
